/* src/ece_pkg.sv */
`default_nettype none

package ece_pkg;

  localparam int unsigned ECE_FRAC_BITS = 16;
  localparam int unsigned IQ = 28;

  // pipeline stage indices
  localparam int unsigned ST_FRONT   = 1;
  localparam int unsigned ST_SQUARE  = 2;
  localparam int unsigned ST_CUBE    = 3;
  localparam int unsigned ST_FIFTH   = 4;
  localparam int unsigned ST_SIN_LO  = 5;
  localparam int unsigned ST_SIN_HI  = 10;
  localparam int unsigned ST_SIN_END = 11;
  localparam int unsigned ST_EXP_LO  = 2;
  localparam int unsigned ST_EXP_HI  = 11;
  localparam int unsigned ST_EXP_SH  = 12;
  localparam int unsigned ST_MIX     = 13;
  localparam int unsigned SQ_FIRST   = 4;
  localparam int unsigned SQ_ITERS   = 29;
  localparam int unsigned ST_ROOT    = SQ_FIRST + SQ_ITERS;
  localparam int unsigned NSTG       = ST_ROOT;

  // curve codes
  localparam logic [4:0] M_LINEAR      = 5'd0;
  localparam logic [4:0] M_SINE_IN     = 5'd1;
  localparam logic [4:0] M_CUBIC_IN    = 5'd2;
  localparam logic [4:0] M_QUINT_IN    = 5'd3;
  localparam logic [4:0] M_CIRC_IN     = 5'd4;
  localparam logic [4:0] M_ELASTIC_IN  = 5'd5;
  localparam logic [4:0] M_BACK_IN     = 5'd6;
  localparam logic [4:0] M_BOUNCE_IN   = 5'd7;
  localparam logic [4:0] M_SINE_OUT    = 5'd8;
  localparam logic [4:0] M_CUBIC_OUT   = 5'd9;
  localparam logic [4:0] M_QUINT_OUT   = 5'd10;
  localparam logic [4:0] M_CIRC_OUT    = 5'd11;
  localparam logic [4:0] M_ELASTIC_OUT = 5'd12;
  localparam logic [4:0] M_BACK_OUT    = 5'd13;
  localparam logic [4:0] M_BOUNCE_OUT  = 5'd14;
  localparam logic [4:0] M_SINE_IO     = 5'd15;
  localparam logic [4:0] M_CUBIC_IO    = 5'd16;
  localparam logic [4:0] M_QUINT_IO    = 5'd17;
  localparam logic [4:0] M_CIRC_IO     = 5'd18;
  localparam logic [4:0] M_ELASTIC_IO  = 5'd19;
  localparam logic [4:0] M_BACK_IO     = 5'd20;
  localparam logic [4:0] M_BOUNCE_IO   = 5'd21;

  typedef logic signed [33:0] qv_t;

  localparam qv_t ONE     = 34'sd268435456;
  localparam qv_t HALF    = 34'sd134217728;
  localparam qv_t QUARTER = 34'sd67108864;
  localparam qv_t TWO     = 34'sd536870912;
  localparam qv_t TEN     = 34'sd2684354560;
  localparam qv_t C43     = 34'sd2885681152;
  localparam qv_t C3Q     = 34'sd201326592;
  localparam qv_t C89     = 34'sd2986344448;
  localparam qv_t K_C1        = 34'sd456764403;
  localparam qv_t K_C3        = 34'sd725199859;
  localparam qv_t K_C2        = 34'sd696565715;
  localparam qv_t K_C2P1      = 34'sd965001171;
  localparam qv_t K_THIRD     = 34'sd89478485;
  localparam qv_t K_TWONINTHS = 34'sd59652324;

  localparam qv_t SIN_C [0:6] = '{
    34'sd421657428, -34'sd173399667, 34'sd21392327, -34'sd1256749,
    34'sd43068, -34'sd966, 34'sd19
  };
  localparam qv_t EXP2_C [0:10] = '{
    34'sd268435456, 34'sd186065280, 34'sd64485312, 34'sd14899271,
    34'sd2581847, 34'sd357920, 34'sd41349, 34'sd4094, 34'sd355,
    34'sd27, 34'sd2
  };

  typedef struct packed {
    logic [4:0]         mode;
    logic               lo;
    logic               at_end;
    logic signed [29:0] x;
    qv_t                y;
    qv_t                y2;
    qv_t                y3;
    qv_t                y4;
    qv_t                y5;
    qv_t                m20;
    qv_t                c1y2;
    qv_t                c3y3;
    qv_t                p20;
    logic [27:0]        w;
    logic [1:0]         q;
    logic [28:0]        u;
    qv_t                u2;
    qv_t                sacc;
    qv_t                sv;
    logic [3:0]         n;
    logic [28:0]        f;
    qv_t                pacc;
    logic [29:0]        p2;
    logic [28:0]        b;
    logic signed [31:0] by;
    logic [27:0]        bc;
    logic [29:0]        bo;
    logic [57:0]        rem;
    logic [57:0]        root;
    qv_t                r;
  } stg_t;

  function automatic qv_t mulq(input qv_t a, input qv_t b);
    logic signed [67:0] p;
    p = a * b;
    p = p + 68'sd134217728;
    return p[61:28];
  endfunction

  function automatic qv_t halfq(input qv_t a);
    qv_t t;
    t = a + 34'sd1;
    return t >>> 1;
  endfunction

  function automatic stg_t stage_step(input int unsigned j, input stg_t i);
    stg_t               o;
    qv_t                xq;
    qv_t                x2q;
    qv_t                x10;
    qv_t                x20;
    qv_t                t;
    qv_t                mq;
    qv_t                nn;
    qv_t                k;
    qv_t                c;
    qv_t                sq;
    logic               lo;
    logic [27:0]        ut;
    logic [57:0]        bitv;
    logic [57:0]        trial;
    logic signed [63:0] bp;
    logic signed [67:0] pp;
    o   = i;
    xq  = qv_t'(i.x);
    x2q = xq <<< 1;
    x10 = xq * 34'sd10;
    x20 = xq * 34'sd20;
    lo  = xq < HALF;

    if (j == ST_FRONT) begin
      o.lo     = lo;
      o.at_end = (xq == 34'sd0) || (xq == ONE);
      case (i.mode)
        M_CUBIC_OUT, M_QUINT_OUT: o.y = ONE - xq;
        M_CIRC_OUT, M_BACK_OUT:   o.y = xq - ONE;
        M_CUBIC_IO, M_QUINT_IO:   o.y = lo ? xq : TWO - x2q;
        M_CIRC_IO:                o.y = lo ? x2q : TWO - x2q;
        M_BACK_IO:                o.y = lo ? x2q : x2q - TWO;
        default:                  o.y = xq;
      endcase
      case (i.mode)
        M_SINE_IN:  t = (xq >>> 2) + QUARTER;
        M_SINE_OUT: t = xq >>> 2;
        M_SINE_IO:  t = (xq >>> 1) + QUARTER;
        default:    t = '0;
      endcase
      o.w = t[27:0];
      case (i.mode)
        M_ELASTIC_IN:  mq = TEN - x10;
        M_ELASTIC_OUT: mq = x10;
        M_ELASTIC_IO:  mq = lo ? TEN - x20 : x20 - TEN;
        default:       mq = '0;
      endcase
      nn  = (mq + ONE - 34'sd1) >>> IQ;
      o.n = nn[3:0];
      t   = (qv_t'(o.n) <<< IQ) - mq;
      o.f = t[28:0];
      case (i.mode)
        M_BOUNCE_IN:  t = ONE - xq;
        M_BOUNCE_OUT: t = xq;
        M_BOUNCE_IO:  t = lo ? ONE - x2q : x2q - ONE;
        default:      t = '0;
      endcase
      o.b = t[28:0];
    end

    if (j == ST_SQUARE) begin
      o.y2  = mulq(i.y, i.y);
      o.m20 = mulq(K_C2P1, i.y);
      case (i.mode)
        M_ELASTIC_IN:  t = mulq(x10 - C43, K_THIRD);
        M_ELASTIC_OUT: t = mulq(x10 - C3Q, K_THIRD);
        M_ELASTIC_IO:  t = mulq(x20 - C89, K_TWONINTHS);
        default:       t = qv_t'(i.w);
      endcase
      o.w = t[27:0];
      t = qv_t'(i.b) * 34'sd11;
      if (t < (ONE <<< 2)) begin
        k = '0;
        c = '0;
      end else if (t < (ONE <<< 3)) begin
        k = ONE * 34'sd6;
        c = 34'sd201326592;
      end else if (t < TEN) begin
        k = ONE * 34'sd9;
        c = 34'sd251658240;
      end else begin
        k = 34'sd2818572288;
        c = 34'sd264241152;
      end
      t    = t - k;
      o.by = t[31:0];
      o.bc = c[27:0];
    end

    if ((j >= ST_EXP_LO) && (j <= ST_EXP_HI)) begin
      o.pacc = EXP2_C[ST_EXP_HI - j] +
               mulq((j == ST_EXP_LO) ? EXP2_C[10] : i.pacc, qv_t'(i.f));
    end

    if (j == ST_CUBE) begin
      o.y3   = mulq(i.y2, i.y);
      o.y4   = mulq(i.y2, i.y2);
      o.c1y2 = mulq(K_C1, i.y2);
      o.p20  = mulq(i.y2, i.lo ? i.m20 - K_C2 : i.m20 + K_C2);
      t      = ONE - i.y2;
      o.rem  = t[33] ? '0 : (58'(t) << IQ);
      o.root = '0;
      ut     = {i.w[25:0], 2'b00};
      o.q    = i.w[27:26];
      o.u    = i.w[26] ? (29'd268435456 - {1'b0, ut}) : {1'b0, ut};
      bp     = i.by * i.by;
      bp     = bp + 64'sd2147483648;
      o.bo   = bp[61:32] + {2'b00, i.bc};
    end

    if (j == ST_FIFTH) begin
      o.y5   = mulq(i.y4, i.y);
      o.c3y3 = mulq(K_C3, i.y3);
      o.u2   = mulq(qv_t'(i.u), qv_t'(i.u));
    end

    if ((j >= ST_SIN_LO) && (j <= ST_SIN_HI)) begin
      o.sacc = SIN_C[ST_SIN_HI - j] +
               mulq((j == ST_SIN_LO) ? SIN_C[6] : i.sacc, i.u2);
    end

    if (j == ST_SIN_END) begin
      t    = mulq(i.sacc, qv_t'(i.u));
      o.sv = i.q[1] ? -t : t;
    end

    if (j == ST_EXP_SH) begin
      k    = (i.n == 4'd0) ? '0 : (34'sd1 <<< (i.n - 4'd1));
      t    = (i.pacc + k) >>> i.n;
      o.p2 = t[29:0];
    end

    if (j == ST_MIX) begin
      t  = mulq(qv_t'(i.p2), i.sv);
      pp = qv_t'(i.p2) * i.sv;
      pp = pp + 68'sd268435456;
      c  = pp[62:29];
      case (i.mode)
        M_SINE_IN:     o.r = ONE - i.sv;
        M_SINE_OUT:    o.r = i.sv;
        M_SINE_IO:     o.r = halfq(ONE - i.sv);
        M_CUBIC_IN:    o.r = i.y3;
        M_QUINT_IN:    o.r = i.y5;
        M_BACK_IN:     o.r = i.c3y3 - i.c1y2;
        M_CUBIC_OUT:   o.r = ONE - i.y3;
        M_QUINT_OUT:   o.r = ONE - i.y5;
        M_BACK_OUT:    o.r = ONE + i.c3y3 + i.c1y2;
        M_CUBIC_IO:    o.r = i.lo ? (i.y3 <<< 2) : ONE - halfq(i.y3);
        M_QUINT_IO:    o.r = i.lo ? (i.y5 <<< 4) : ONE - halfq(i.y5);
        M_BACK_IO:     o.r = i.lo ? halfq(i.p20) : halfq(i.p20 + TWO);
        M_BOUNCE_IN:   o.r = ONE - qv_t'(i.bo);
        M_BOUNCE_OUT:  o.r = qv_t'(i.bo);
        M_BOUNCE_IO:   o.r = i.lo ? halfq(ONE - qv_t'(i.bo)) : halfq(ONE + qv_t'(i.bo));
        M_ELASTIC_IN:  o.r = i.at_end ? xq : -t;
        M_ELASTIC_OUT: o.r = i.at_end ? xq : t + ONE;
        M_ELASTIC_IO:  o.r = i.at_end ? xq : (i.lo ? -c : c + ONE);
        default:       o.r = xq;
      endcase
    end

    if ((j >= SQ_FIRST) && (j < SQ_FIRST + SQ_ITERS)) begin
      bitv  = 58'd1 << (56 - 2 * (j - SQ_FIRST));
      trial = i.root + bitv;
      if (i.rem >= trial) begin
        o.rem  = i.rem - trial;
        o.root = (i.root >> 1) + bitv;
      end else begin
        o.root = i.root >> 1;
      end
    end

    if (j == ST_ROOT) begin
      sq = qv_t'(i.root[28:0]);
      case (i.mode)
        M_CIRC_IN:  o.r = ONE - sq;
        M_CIRC_OUT: o.r = sq;
        M_CIRC_IO:  o.r = i.lo ? halfq(ONE - sq) : halfq(sq + ONE);
        default:    o.r = i.r;
      endcase
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* src/ece_stage.sv */
`default_nettype none

module ece_stage
  import ece_pkg::*;
#(
  parameter int unsigned IDX = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  input  stg_t up_data,
  input  logic dn_ready,
  output logic ready,
  output logic valid,
  output stg_t data
);

  assign ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= stage_step(IDX, up_data);
    end
  end

endmodule

`default_nettype wire

/* src/easing_curve_evaluator.sv */
`default_nettype none

// Easing curve evaluator: one beat carries a curve code and a progress value
// (unsigned Q1.FRAC_BITS, saturated at 1.0) and returns the curve value as
// signed Q2.FRAC_BITS. Codes 22..31 act as linear. Fully pipelined: one beat
// is taken every cycle while the output is not stalled; each result passes
// every stage register and then the output register. The depth is set by
// the 29-step square-root pipeline used by the circular curves; sine and
// power-of-two polynomials run beside it. Bubbles are squeezed out, so input
// beats keep being taken while a result waits at the output, until the stages fill.
module easing_curve_evaluator
  import ece_pkg::*;
#(
  parameter int unsigned FRAC_BITS = ECE_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [4:0]                  mode,
  input  logic [FRAC_BITS:0]          progress,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [FRAC_BITS+1:0] eased
);

  localparam int unsigned SH = IQ - FRAC_BITS;
  localparam logic [FRAC_BITS:0] PONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam qv_t RBIAS = 34'sd1 <<< (SH - 1);
  localparam qv_t MAXV  = (34'sd1 <<< (FRAC_BITS + 1)) - 34'sd1;
  localparam qv_t MINV  = -(34'sd1 <<< (FRAC_BITS + 1));

  stg_t              sd [0:NSTG];
  logic [NSTG:0]     vld;
  logic [NSTG+1:1]   rdy;
  logic [FRAC_BITS:0] psat;
  qv_t               rr;
  qv_t               rs;

  assign psat = (progress > PONE) ? PONE : progress;

  always_comb begin
    sd[0]      = '0;
    sd[0].mode = mode;
    sd[0].x    = $signed(30'(psat) << SH);
  end

  assign vld[0]     = item_valid;
  assign item_stall = !rdy[1];

  for (genvar k = 1; k <= NSTG; k++) begin : g_stg
    ece_stage #(
      .IDX(k)
    ) u_stg (
      .clk     (clk),
      .rst     (rst),
      .up_valid(vld[k-1]),
      .up_data (sd[k-1]),
      .dn_ready(rdy[k+1]),
      .ready   (rdy[k]),
      .valid   (vld[k]),
      .data    (sd[k])
    );
  end

  assign rdy[NSTG+1] = !result_valid || !result_stall;

  always_comb begin
    rr = (sd[NSTG].r + RBIAS) >>> SH;
    if (rr > MAXV) begin
      rs = MAXV;
    end else if (rr < MINV) begin
      rs = MINV;
    end else begin
      rs = rr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rdy[NSTG+1]) begin
      result_valid <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG+1]) begin
      eased <= rs[FRAC_BITS+1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with an empty output register");
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_stall)
    else $error("input stalled while output drains");
  a_enter : assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> vld[1])
    else $error("accepted beat missing from first stage");
  a_drain : assert property (@(posedge clk) disable iff (rst)
    (vld[NSTG] && !result_stall) |=> result_valid)
    else $error("finished beat not moved to output");
`endif

endmodule

`default_nettype wire

/* tb/tb_easing_curve_evaluator.sv */
`default_nettype none

module tb_easing_curve_evaluator;
  import ece_pkg::*;

  localparam int FB = ECE_FRAC_BITS;
  localparam int NRAND = 1750;
  localparam longint ONE_Q = 64'sd1 << 28;
  localparam longint HALF_Q = 64'sd1 << 27;
  localparam int LIMIT_CYC = 400000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic [4:0] mode;
  logic [FB:0] progress;
  logic result_valid;
  logic result_stall;
  logic signed [FB+1:0] eased;

  easing_curve_evaluator uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .progress(progress),
    .result_valid(result_valid), .result_stall(result_stall),
    .eased(eased)
  );

  typedef struct {
    logic [4:0] m;
    logic [FB:0] p;
    logic chk;
    logic signed [FB+1:0] val;
  } row_t;

  logic signed [FB+1:0] pending_eased[$];
  int mismatches;
  int cycles;
  bit hold_rx;

  function automatic longint rnd_half_up(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul28(longint a, longint b);
    return rnd_half_up(a * b, 28);
  endfunction

  function automatic longint halve(longint a);
    return rnd_half_up(a, 1);
  endfunction

  function automatic longint sine_turns(longint t);
    longint sc[7] = '{421657428, -173399667, 21392327, -1256749, 43068, -966, 19};
    longint w, u, u2, acc;
    int q;
    w = t & (ONE_Q - 1);
    q = int'(w >> 26);
    u = (w & ((64'sd1 << 26) - 1)) << 2;
    if (q[0]) u = ONE_Q - u;
    u2 = mul28(u, u);
    acc = sc[6];
    for (int i = 5; i >= 0; i--) acc = sc[i] + mul28(acc, u2);
    acc = mul28(acc, u);
    return q[1] ? -acc : acc;
  endfunction

  function automatic longint root28(longint a);
    logic [63:0] rem, res, bitv;
    res = 0;
    bitv = 64'd1 << 56;
    if (a <= 0) return 0;
    if (a > ONE_Q) a = ONE_Q;
    rem = 64'(a) << 28;
    for (int i = 0; i < 29; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint exp2_neg(longint e);
    longint ec[11] = '{268435456, 186065280, 64485312, 14899271, 2581847, 357920,
                       41349, 4094, 355, 27, 2};
    longint m, n, f, acc;
    if (e > 0) e = 0;
    m = -e;
    n = (m + ONE_Q - 1) >> 28;
    if (n > 40) return 0;
    f = (n << 28) - m;
    acc = ec[10];
    for (int i = 9; i >= 0; i--) acc = ec[i] + mul28(acc, f);
    return rnd_half_up(acc, int'(n));
  endfunction

  function automatic longint bounce_tail(longint x);
    longint k, c, y, x11;
    x11 = 11 * x;
    if (x11 < 4 * ONE_Q) begin k = 0; c = 0; end
    else if (x11 < 8 * ONE_Q) begin k = 6 * ONE_Q; c = (ONE_Q * 3) / 4; end
    else if (x11 < 10 * ONE_Q) begin k = 9 * ONE_Q; c = (ONE_Q * 15) / 16; end
    else begin k = 21 * HALF_Q; c = (ONE_Q * 63) / 64; end
    y = x11 - k;
    return rnd_half_up(y * y, 32) + c;
  endfunction

  function automatic longint ease_q28(logic [4:0] m, longint x);
    longint x2, x3, y, y2, t, c1, c3, c2, c2p1, k3, k29;
    bit lo, at_end;
    c1 = 456764403; c3 = 725199859; c2 = 696565715; c2p1 = 965001171;
    k3 = 89478485; k29 = 59652324;
    x2 = mul28(x, x);
    x3 = mul28(x2, x);
    lo = x < HALF_Q;
    at_end = (x == 0) || (x == ONE_Q);
    case (m)
      M_SINE_IN: return ONE_Q - sine_turns((x >>> 2) + (ONE_Q >>> 2));
      M_CUBIC_IN: return x3;
      M_QUINT_IN: return mul28(mul28(x2, x2), x);
      M_CIRC_IN: return ONE_Q - root28(ONE_Q - x2);
      M_ELASTIC_IN: begin
        if (at_end) return x;
        return -mul28(exp2_neg(10 * x - 10 * ONE_Q),
                      sine_turns(mul28(10 * x - 43 * (ONE_Q >>> 2), k3)));
      end
      M_BACK_IN: return mul28(c3, x3) - mul28(c1, x2);
      M_BOUNCE_IN: return ONE_Q - bounce_tail(ONE_Q - x);
      M_SINE_OUT: return sine_turns(x >>> 2);
      M_CUBIC_OUT: begin y = ONE_Q - x; return ONE_Q - mul28(mul28(y, y), y); end
      M_QUINT_OUT: begin
        y = ONE_Q - x; y2 = mul28(y, y);
        return ONE_Q - mul28(mul28(y2, y2), y);
      end
      M_CIRC_OUT: begin y = x - ONE_Q; return root28(ONE_Q - mul28(y, y)); end
      M_ELASTIC_OUT: begin
        if (at_end) return x;
        return mul28(exp2_neg(-10 * x),
                     sine_turns(mul28(10 * x - 3 * (ONE_Q >>> 2), k3))) + ONE_Q;
      end
      M_BACK_OUT: begin
        y = x - ONE_Q; y2 = mul28(y, y);
        return ONE_Q + mul28(c3, mul28(y2, y)) + mul28(c1, y2);
      end
      M_BOUNCE_OUT: return bounce_tail(x);
      M_SINE_IO: return halve(ONE_Q - sine_turns((x >>> 1) + (ONE_Q >>> 2)));
      M_CUBIC_IO: begin
        if (lo) return 4 * x3;
        y = 2 * ONE_Q - 2 * x;
        return ONE_Q - halve(mul28(mul28(y, y), y));
      end
      M_QUINT_IO: begin
        if (lo) return 16 * mul28(mul28(x2, x2), x);
        y = 2 * ONE_Q - 2 * x; y2 = mul28(y, y);
        return ONE_Q - halve(mul28(mul28(y2, y2), y));
      end
      M_CIRC_IO: begin
        if (lo) begin
          y = 2 * x;
          return halve(ONE_Q - root28(ONE_Q - mul28(y, y)));
        end
        y = 2 * ONE_Q - 2 * x;
        return halve(root28(ONE_Q - mul28(y, y)) + ONE_Q);
      end
      M_ELASTIC_IO: begin
        if (at_end) return x;
        t = sine_turns(mul28(20 * x - 89 * (ONE_Q >>> 3), k29));
        if (lo) return -rnd_half_up(exp2_neg(20 * x - 10 * ONE_Q) * t, 29);
        return rnd_half_up(exp2_neg(10 * ONE_Q - 20 * x) * t, 29) + ONE_Q;
      end
      M_BACK_IO: begin
        if (lo) begin
          y = 2 * x;
          return halve(mul28(mul28(y, y), mul28(c2p1, y) - c2));
        end
        y = 2 * x - 2 * ONE_Q;
        return halve(mul28(mul28(y, y), mul28(c2p1, y) + c2) + 2 * ONE_Q);
      end
      M_BOUNCE_IO: begin
        if (lo) return halve(ONE_Q - bounce_tail(ONE_Q - 2 * x));
        return halve(ONE_Q + bounce_tail(2 * x - ONE_Q));
      end
      default: return x;
    endcase
  endfunction

  function automatic logic signed [FB+1:0] predict_eased(logic [4:0] m, logic [FB:0] p);
    longint pv, r, lim;
    pv = longint'(p);
    if (pv > (64'sd1 << FB)) pv = 64'sd1 << FB;
    r = rnd_half_up(ease_q28(m, pv << (28 - FB)), 28 - FB);
    lim = 64'sd2 << FB;
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r[FB+1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYC) begin
        $display("** easing_curve_evaluator: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stall per beat, with one long hold-off
  initial begin
    int gap;
    result_stall <= 1'b1;
    @(posedge clk iff !rst);
    forever begin
      if (hold_rx) begin
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (cycles > 20000 && cycles < 24000) gap = 0;
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk iff result_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_eased.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: eased=%0d", eased);
      end else begin
        if (eased !== pending_eased[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("eased mismatch: expected %0d actual %0d", pending_eased[0], eased);
        end
        void'(pending_eased.pop_front());
      end
    end
  end

  task automatic send_beat(logic [4:0] m, logic [FB:0] p, bit chk, logic signed [FB+1:0] v,
                           bit fast);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    progress <= p;
    @(posedge clk iff !item_stall);
    pending_eased.push_back(chk ? v : predict_eased(m, p));
  endtask

  initial begin
    row_t rows[$];
    int k;
    logic [4:0] m;
    logic [FB:0] p;
    mismatches = 0;
    hold_rx = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    mode <= '0;
    progress <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{M_LINEAR, 17'd0, 1'b1, 18'sd0});
    rows.push_back('{M_LINEAR, 17'd65536, 1'b1, 18'sd65536});
    rows.push_back('{M_LINEAR, 17'h1FFFF, 1'b1, 18'sd65536});
    rows.push_back('{5'd31, 17'd12345, 1'b1, 18'sd12345});
    rows.push_back('{5'd22, 17'd70000, 1'b1, 18'sd65536});
    rows.push_back('{M_ELASTIC_IN, 17'd0, 1'b1, 18'sd0});
    rows.push_back('{M_ELASTIC_OUT, 17'd65536, 1'b1, 18'sd65536});
    rows.push_back('{M_ELASTIC_IO, 17'd100000, 1'b1, 18'sd65536});
    rows.push_back('{M_CUBIC_IN, 17'd65536, 1'b1, 18'sd65536});
    rows.push_back('{M_BACK_IO, 17'd32768, 1'b0, 18'sd0});
    rows.push_back('{M_ELASTIC_IO, 17'd32768, 1'b0, 18'sd0});
    rows.push_back('{M_CIRC_IO, 17'd32767, 1'b0, 18'sd0});
    for (int i = 1; i <= 21; i += 2)
      rows.push_back('{5'(i), 17'($urandom_range(1, 65535)), 1'b0, 18'sd0});

    foreach (rows[i]) send_beat(rows[i].m, rows[i].p, rows[i].chk, rows[i].val, 0);

    for (k = 0; k < NRAND; k++) begin
      case ($urandom_range(0, 9))
        0: p = 17'($urandom);
        1: p = 17'($urandom_range(0, 3));
        2: p = 17'($urandom_range(65533, 65536));
        3: p = 17'($urandom_range(32766, 32770));
        default: p = 17'($urandom_range(0, 65536));
      endcase
      m = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 21));
      if (k == 500) hold_rx = 1'b1;
      send_beat(m, p, 0, 18'sd0, (k >= 500 && k < 600));
      if (k == 1000) begin
        item_valid <= 1'b0;
        @(posedge clk iff pending_eased.size() == 0);
      end
    end
    item_valid <= 1'b0;
    @(posedge clk iff pending_eased.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_eased.size() == 0) begin
      $display("** easing_curve_evaluator: PASSED **");
    end else begin
      $display("** easing_curve_evaluator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/ece_pkg.sv
src/ece_stage.sv
src/easing_curve_evaluator.sv
tb/tb_easing_curve_evaluator.sv
